[sv/pcha_pkg.sv]
// ----------------------------------------------------------------------------
// pcha_pkg
// Sizes, field widths and status codes for the page chunk heap allocator.
// ----------------------------------------------------------------------------
package pcha_pkg;

  localparam int HEAP_PAGES   = 64;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;

  localparam int PG_W    = $clog2(HEAP_PAGES);
  localparam int LEN_W   = $clog2(HEAP_PAGES + 1);
  localparam int ENT_W   = LEN_W + 1;
  localparam int PAGE_SH = $clog2(PAGE_BYTES);

  localparam int REQ_W  = 19;
  localparam int ADDR_W = 18;
  localparam int STAT_W = 2;
  localparam int TOT_W  = REQ_W + 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

endpackage

[sv/page_chunk_heap_allocator.sv]
// ----------------------------------------------------------------------------
// page_chunk_heap_allocator
// First-fit page allocator with split and two-sided coalescing.
// ----------------------------------------------------------------------------
// The heap is HEAP_PAGES pages kept as an address-ordered run of chunks; the
// chunk table (length and used flag per start page) sits in one synchronous
// memory with one read and one write port. An allocate item rounds bytes plus
// header up to pages, walks the chunks from page 0 and takes the first free
// one that fits, splitting off the rest, else appends at the heap top. A free
// item marks its chunk free and merges it with free neighbors. Each item gives
// one result. An allocate walks the chunks up to the one it takes, a free walks
// the chunks below its own; the walk reads one table entry per cycle.
// One item is in work at a time; the next is taken while the previous result
// still waits at the output.
// Entry valid bits are cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_chunk_heap_allocator
  import pcha_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // request_bytes[18:0], free_address[36:19]
  input  logic                  in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[1:0], block_address[19:2]
);

  typedef enum logic [3:0] {
    S_IDLE, S_A_WALK, S_A_SPLIT, S_A_TOP,
    S_F_P, S_F_Q, S_F_WALK, S_F_FIN, S_F_ZERO, S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [LEN_W-1:0]      top_r, top_nxt;
  logic [LEN_W-1:0]      need_r, need_nxt;
  logic [LEN_W-1:0]      p_r, p_nxt;
  logic [LEN_W-1:0]      q_r, q_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [PG_W-1:0]       pg_r, pg_nxt;
  status_t               status_r, status_nxt;
  logic [ADDR_W-1:0]     res_addr_r, res_addr_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [ENT_W-1:0]      mem [HEAP_PAGES];
  logic [HEAP_PAGES-1:0] vld_r;
  logic [ENT_W-1:0]      rdata_r;
  logic                  rvld_r;
  logic                  mem_we;
  logic [PG_W-1:0]       mem_waddr;
  logic [ENT_W-1:0]      mem_wdata;
  logic [PG_W-1:0]       mem_raddr;

  logic [LEN_W-1:0]      ent_len;
  logic                  ent_used;

  logic [REQ_W-1:0]      req_bytes;
  logic [ADDR_W-1:0]     req_addr;
  logic [TOT_W:0]        need_rnd;
  logic [TOT_W:0]        need_full;
  logic                  need_oom;
  logic [ADDR_W-1:0]     free_off;
  logic [ADDR_W-1:0]     free_pg;
  logic                  free_bad;
  logic [LEN_W:0]        walk_sum;
  logic [LEN_W:0]        top_sum;

  function automatic logic [ADDR_W-1:0] page_addr(input logic [LEN_W-1:0] pg);
    page_addr = (ADDR_W'(pg) << PAGE_SH) + ADDR_W'(HEADER_BYTES);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign ent_len  = rvld_r ? rdata_r[LEN_W-1:0] : '0;
  assign ent_used = rvld_r & rdata_r[LEN_W];

  assign req_bytes = in_tdata[REQ_W-1:0];
  assign req_addr  = in_tdata[REQ_W+ADDR_W-1:REQ_W];

  assign need_rnd  = {1'b0, TOT_W'(req_bytes) + TOT_W'(HEADER_BYTES)}
                   + (TOT_W+1)'(PAGE_BYTES - 1);
  assign need_full = need_rnd >> PAGE_SH;
  assign need_oom  = (need_full == '0) || (need_full > (TOT_W+1)'(HEAP_PAGES));

  assign free_off = req_addr - ADDR_W'(HEADER_BYTES);
  assign free_pg  = free_off >> PAGE_SH;
  assign free_bad = (req_addr < ADDR_W'(HEADER_BYTES))
                 || (free_off[PAGE_SH-1:0] != '0)
                 || (free_pg >= ADDR_W'(top_r));

  assign walk_sum = {1'b0, p_r} + {1'b0, ent_len};
  assign top_sum  = {1'b0, top_r} + {1'b0, need_r};

  // chunk table; a read of the entry being written is flagged invalid by rvld_r
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      rvld_r <= vld_r[mem_raddr] & ~(mem_we && (mem_waddr == mem_raddr));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    need_nxt       = need_r;
    p_nxt          = p_r;
    q_nxt          = q_r;
    len_nxt        = len_r;
    pg_nxt         = pg_r;
    status_nxt     = status_r;
    res_addr_nxt   = res_addr_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = '0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_addr_nxt = '0;
          if (in_tuser == REQ_ALLOC) begin
            need_nxt = LEN_W'(need_full);
            p_nxt    = '0;
            if (need_oom) begin
              status_nxt = ST_OOM;
              state_nxt  = S_RESP;
            end else if (top_r == '0) begin
              state_nxt = S_A_TOP;
            end else begin
              state_nxt = S_A_WALK;
            end
          end else begin
            pg_nxt    = PG_W'(free_pg);
            mem_raddr = PG_W'(free_pg);
            if (free_bad) begin
              status_nxt = ST_BADFREE;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_F_P;
            end
          end
        end
      end

      S_A_WALK: begin
        if (ent_len == '0) begin
          state_nxt = S_A_TOP;
        end else if (!ent_used && (ent_len >= need_r)) begin
          mem_we       = 1'b1;
          mem_waddr    = p_r[PG_W-1:0];
          mem_wdata    = {1'b1, need_r};
          len_nxt      = ent_len;
          status_nxt   = ST_OK;
          res_addr_nxt = page_addr(p_r);
          state_nxt    = (ent_len > need_r) ? S_A_SPLIT : S_RESP;
        end else if (walk_sum < {1'b0, top_r}) begin
          p_nxt     = walk_sum[LEN_W-1:0];
          mem_raddr = walk_sum[PG_W-1:0];
        end else begin
          state_nxt = S_A_TOP;
        end
      end

      S_A_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = PG_W'(p_r + need_r);
        mem_wdata = {1'b0, len_r - need_r};
        state_nxt = S_RESP;
      end

      S_A_TOP: begin
        if (top_sum > (LEN_W+1)'(HEAP_PAGES)) begin
          status_nxt = ST_OOM;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = top_r[PG_W-1:0];
          mem_wdata    = {1'b1, need_r};
          top_nxt      = top_sum[LEN_W-1:0];
          status_nxt   = ST_OK;
          res_addr_nxt = page_addr(top_r);
        end
        state_nxt = S_RESP;
      end

      S_F_P: begin
        if ((ent_len == '0) || !ent_used) begin
          status_nxt = ST_BADFREE;
          state_nxt  = S_RESP;
        end else begin
          status_nxt = ST_OK;
          len_nxt    = ent_len;
          q_nxt      = LEN_W'({1'b0, pg_r} + ent_len);
          if (({1'b0, pg_r} + {1'b0, ent_len}) < {1'b0, top_r}) begin
            mem_raddr = PG_W'(pg_r + ent_len);
            state_nxt = S_F_Q;
          end else if (pg_r == '0) begin
            state_nxt = S_F_FIN;
          end else begin
            p_nxt     = '0;
            state_nxt = S_F_WALK;
          end
        end
      end

      S_F_Q: begin
        if ((ent_len != '0) && !ent_used) begin
          mem_we    = 1'b1;
          mem_waddr = q_r[PG_W-1:0];
          mem_wdata = '0;
          len_nxt   = len_r + ent_len;
        end
        if (pg_r == '0) begin
          state_nxt = S_F_FIN;
        end else begin
          p_nxt     = '0;
          state_nxt = S_F_WALK;
        end
      end

      S_F_WALK: begin
        if (ent_len == '0) begin
          state_nxt = S_F_FIN;
        end else if (walk_sum == (LEN_W+1)'(pg_r)) begin
          if (!ent_used) begin
            mem_we    = 1'b1;
            mem_waddr = p_r[PG_W-1:0];
            mem_wdata = {1'b0, ent_len + len_r};
            state_nxt = S_F_ZERO;
          end else begin
            state_nxt = S_F_FIN;
          end
        end else if (walk_sum < (LEN_W+1)'(pg_r)) begin
          p_nxt     = walk_sum[LEN_W-1:0];
          mem_raddr = walk_sum[PG_W-1:0];
        end else begin
          state_nxt = S_F_FIN;
        end
      end

      S_F_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = pg_r;
        mem_wdata = {1'b0, len_r};
        state_nxt = S_RESP;
      end

      S_F_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = pg_r;
        mem_wdata = '0;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_DATA_W'({res_addr_r, status_r});
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      top_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      top_r        <= top_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      need_r       <= need_nxt;
      p_r          <= p_nxt;
      q_r          <= q_nxt;
      len_r        <= len_nxt;
      pg_r         <= pg_nxt;
      status_r     <= status_nxt;
      res_addr_r   <= res_addr_nxt;
      out_tdata_r  <= out_tdata_nxt;
    end
  end

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= LEN_W'(HEAP_PAGES))
    else $error("heap top past heap size");

  a_top_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> top_r >= $past(top_r))
    else $error("heap top shrank");

  a_walk_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_WALK) |-> p_r < top_r)
    else $error("allocate walk past heap top");

  a_free_walk_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_F_WALK) |-> p_r < LEN_W'(pg_r))
    else $error("predecessor walk reached freed chunk");

  a_ok_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && status_r == ST_OK && res_addr_r != '0)
      |-> res_addr_r[PAGE_SH-1:0] == PAGE_SH'(HEADER_BYTES))
    else $error("allocated address not page plus header");

endmodule
